>>> sv/lruk_pkg.sv
// Shared types and codes for the LRU-K victim selector.
// Holds the request/response payload structs, command and error codes, and the FSM states.
// No dependencies.
package lruk_pkg;

  typedef enum logic [1:0] {
    CMD_ACCESS        = 2'd0,
    CMD_SET_EVICTABLE = 2'd1,
    CMD_REMOVE        = 2'd2,
    CMD_EVICT         = 2'd3
  } cmd_t;

  localparam logic [1:0] ERR_OK            = 2'd0;
  localparam logic [1:0] ERR_RANGE         = 2'd1;
  localparam logic [1:0] ERR_NOT_EVICTABLE = 2'd2;

  // Register index as seen on paddr[2]
  localparam logic REG_HISTORY_DEPTH = 1'b0;
  localparam logic REG_FRAMES_IN_USE = 1'b1;

  localparam logic [3:0] HISTORY_DEPTH_RESET = 4'd2;
  localparam logic [4:0] FRAMES_IN_USE_RESET = 5'd16;

  typedef struct packed {
    cmd_t       cmd;
    logic [3:0] frame;
    logic       evictable_value;
  } req_t;

  typedef struct packed {
    logic       victim_found;
    logic [3:0] victim_frame;
    logic [4:0] evictable_count;
    logic [1:0] error_code;
  } rsp_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ACC_WR,
    S_EV_SCAN,
    S_EV_DONE,
    S_RESP
  } state_t;

endpackage

>>> sv/lruk_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
module lruk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> sv/lru_k_replacement_policy_top.sv
// LRU-K victim selector: top level with sequencer, frame flags and the evict scan.
// Depends on lruk_pkg and lruk_ram (per-frame count/pointer RAM and timestamp history RAM).
//
// Usage:
//   req channel (valid/ready) carries one command: record access, set evictable, remove,
//   evict. rsp channel (valid/ready) returns exactly one result per command. The block
//   handles one command at a time and is ready only while idle.
//   Steps from request transfer to result in the output register:
//     set evictable, remove, rejected access: straight to the response state
//     record access: read of the frame's count/pointer, then history write
//     evict: the scan issues one frame per cycle through a three-stage loop
//     (count/pointer RAM read, history RAM read, shared oldest-timestamp comparator).
//   The next request is taken the cycle after the result loads.
//   History is a ring of K_MAX timestamps per frame in RAM, so an access writes one entry.
//   Registers sit on an APB port: history_depth at 0x0, frames_in_use at 0x4; write them
//   only while the block is idle.
//   Reset: all frames untracked, evictable count and timestamp zero, registers to their
//   defaults. The history RAM is not cleared; only entries written since a frame became
//   tracked are ever read.
//   A stalled receiver holds the result in the output register; the block still takes and
//   works the next command, then waits with that result until the register frees.
module lru_k_replacement_policy_top #(
  parameter int FRAMES    = 16,
  parameter int K_MAX     = 8,
  parameter int TIME_BITS = 48
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  lruk_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_ready,
  output lruk_pkg::rsp_t rsp,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  localparam int FW  = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int SW  = (K_MAX > 1) ? $clog2(K_MAX) : 1;
  localparam int CW  = $clog2(K_MAX + 1);
  localparam int TW  = $clog2(FRAMES + 1);
  localparam int SCW = $clog2(FRAMES + 2);
  localparam int MW  = CW + SW;
  localparam int HAW = FW + SW;
  localparam int PW  = CW + 1;

  // Configuration registers
  logic [3:0] history_depth;
  logic [4:0] frames_in_use;

  // Control state
  lruk_pkg::state_t state, state_next;
  logic [FRAMES-1:0]    present, present_next;
  logic [FRAMES-1:0]    evictable, evictable_next;
  logic [TW-1:0]        total, total_next;
  logic [TIME_BITS-1:0] time_now, time_next;
  logic [SCW-1:0]       scan_cnt;
  logic                 s1_valid, s2_valid, best_have;

  // Payload registers
  logic [FW-1:0]        op_frame;
  logic [FW-1:0]        s1_j, s2_j, best_j;
  logic                 s2_inf, best_inf;
  logic [TIME_BITS-1:0] best_old;
  lruk_pkg::rsp_t       pend, pend_next;

  // RAM ports
  logic [FW-1:0]        meta_raddr;
  logic [MW-1:0]        meta_rdata, meta_wdata;
  logic                 mem_we;
  logic [HAW-1:0]       hist_raddr, hist_waddr;
  logic [TIME_BITS-1:0] hist_rdata;

  // Decoded request and control outputs
  logic          req_fire, cfg_wr, issue, rsp_load, in_frames, in_range, better;
  logic [FW-1:0] f_idx, scan_j;
  logic [1:0]    err_next;
  logic [CW-1:0] k_eff;

  // Access datapath
  logic          was_present;
  logic [CW-1:0] cnt_old, cnt_new;
  logic [SW-1:0] ptr_old, ptr_new;

  // Scan stage one
  logic [CW-1:0] s1_cnt, s1_n;
  logic [SW-1:0] s1_ptr, s1_slot;
  logic [PW-1:0] p_ext, n_ext, slot_sum;
  logic          s1_inf;

  assign pready    = 1'b1;
  assign cfg_wr    = psel & penable & pwrite;
  assign req_fire  = req_valid & req_ready;
  assign f_idx     = FW'(req.frame);
  assign in_frames = 32'(req.frame) < FRAMES;
  assign in_range  = in_frames && ({1'b0, req.frame} < frames_in_use);
  assign scan_j    = FW'(scan_cnt);

  always_comb begin
    if (history_depth == 4'd0) begin
      k_eff = CW'(1);
    end else if (32'(history_depth) > K_MAX) begin
      k_eff = CW'(K_MAX);
    end else begin
      k_eff = CW'(history_depth);
    end
  end

  // APB registers
  always_ff @(posedge clk) begin
    if (rst) begin
      history_depth <= lruk_pkg::HISTORY_DEPTH_RESET;
      frames_in_use <= lruk_pkg::FRAMES_IN_USE_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        lruk_pkg::REG_HISTORY_DEPTH: history_depth <= pwdata[3:0];
        lruk_pkg::REG_FRAMES_IN_USE: frames_in_use <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      lruk_pkg::REG_HISTORY_DEPTH: prdata = {28'd0, history_depth};
      lruk_pkg::REG_FRAMES_IN_USE: prdata = {27'd0, frames_in_use};
      default:                     prdata = 32'd0;
    endcase
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      lruk_pkg::S_IDLE: begin
        if (req_valid) begin
          case (req.cmd)
            lruk_pkg::CMD_ACCESS: state_next = in_range ? lruk_pkg::S_ACC_WR : lruk_pkg::S_RESP;
            lruk_pkg::CMD_EVICT:  state_next = lruk_pkg::S_EV_SCAN;
            default:              state_next = lruk_pkg::S_RESP;
          endcase
        end
      end
      lruk_pkg::S_ACC_WR:  state_next = lruk_pkg::S_RESP;
      lruk_pkg::S_EV_SCAN: begin
        if (scan_cnt == SCW'(FRAMES + 1)) begin
          state_next = lruk_pkg::S_EV_DONE;
        end
      end
      lruk_pkg::S_EV_DONE: state_next = lruk_pkg::S_RESP;
      lruk_pkg::S_RESP: begin
        if (!rsp_valid || rsp_ready) begin
          state_next = lruk_pkg::S_IDLE;
        end
      end
      default: state_next = lruk_pkg::S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    req_ready  = 1'b0;
    mem_we     = 1'b0;
    issue      = 1'b0;
    rsp_load   = 1'b0;
    meta_raddr = f_idx;
    unique case (state)
      lruk_pkg::S_IDLE:    req_ready = 1'b1;
      lruk_pkg::S_ACC_WR:  mem_we = 1'b1;
      lruk_pkg::S_EV_SCAN: begin
        issue      = 32'(scan_cnt) < FRAMES;
        meta_raddr = scan_j;
      end
      lruk_pkg::S_EV_DONE: ;
      lruk_pkg::S_RESP:    rsp_load = !rsp_valid || rsp_ready;
      default: ;
    endcase
  end

  // Record access: bump count, advance ring pointer, stamp the time
  always_comb begin
    was_present = present[op_frame];
    cnt_old     = was_present ? meta_rdata[MW-1:SW] : '0;
    ptr_old     = was_present ? meta_rdata[SW-1:0] : '0;
    cnt_new     = (cnt_old == CW'(K_MAX)) ? cnt_old : cnt_old + CW'(1);
    ptr_new     = (ptr_old == SW'(K_MAX - 1)) ? '0 : ptr_old + SW'(1);
    meta_wdata  = {cnt_new, ptr_new};
    hist_waddr  = {op_frame, ptr_old};
  end

  // Scan stage one: locate the oldest of the newest min(count, k) entries in the ring
  always_comb begin
    s1_cnt   = meta_rdata[MW-1:SW];
    s1_ptr   = meta_rdata[SW-1:0];
    s1_inf   = s1_cnt < k_eff;
    s1_n     = s1_inf ? s1_cnt : k_eff;
    p_ext    = PW'(s1_ptr);
    n_ext    = PW'(s1_n);
    slot_sum = (p_ext >= n_ext) ? p_ext - n_ext : p_ext + PW'(K_MAX) - n_ext;
    s1_slot  = SW'(slot_sum);
    hist_raddr = {s1_j, s1_slot};
  end

  // Shared comparator: time only grows, so the largest distance is the smallest timestamp
  assign better = s2_valid &&
                  (!best_have || (s2_inf && !best_inf) ||
                   (s2_inf == best_inf && hist_rdata < best_old));

  // Frame flags, evictable count and time
  always_comb begin
    present_next   = present;
    evictable_next = evictable;
    total_next     = total;
    time_next      = time_now;
    err_next       = lruk_pkg::ERR_OK;
    unique case (state)
      lruk_pkg::S_IDLE: begin
        if (req_fire) begin
          case (req.cmd)
            lruk_pkg::CMD_ACCESS: begin
              if (!in_range) begin
                err_next = lruk_pkg::ERR_RANGE;
              end
            end
            lruk_pkg::CMD_SET_EVICTABLE: begin
              if (in_frames && present[f_idx] && evictable[f_idx] != req.evictable_value) begin
                evictable_next[f_idx] = req.evictable_value;
                if (req.evictable_value) begin
                  total_next = total + TW'(1);
                end else if (total != '0) begin
                  total_next = total - TW'(1);
                end
              end
            end
            lruk_pkg::CMD_REMOVE: begin
              if (in_frames && present[f_idx]) begin
                if (!evictable[f_idx]) begin
                  err_next = lruk_pkg::ERR_NOT_EVICTABLE;
                end else begin
                  present_next[f_idx]   = 1'b0;
                  evictable_next[f_idx] = 1'b0;
                  if (total != '0) begin
                    total_next = total - TW'(1);
                  end
                end
              end
            end
            default: ;
          endcase
        end
      end
      lruk_pkg::S_ACC_WR: begin
        present_next[op_frame] = 1'b1;
        if (time_now != '1) begin
          time_next = time_now + TIME_BITS'(1);
        end
      end
      lruk_pkg::S_EV_DONE: begin
        if (best_have) begin
          present_next[best_j]   = 1'b0;
          evictable_next[best_j] = 1'b0;
          if (total != '0) begin
            total_next = total - TW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    pend_next.victim_found    = (state == lruk_pkg::S_EV_DONE) && best_have;
    pend_next.victim_frame    = pend_next.victim_found ? 4'(best_j) : 4'd0;
    pend_next.evictable_count = 5'(total_next);
    pend_next.error_code      = err_next;
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= lruk_pkg::S_IDLE;
      present   <= '0;
      evictable <= '0;
      total     <= '0;
      time_now  <= '0;
      rsp_valid <= 1'b0;
      scan_cnt  <= '0;
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      best_have <= 1'b0;
    end else begin
      state     <= state_next;
      present   <= present_next;
      evictable <= evictable_next;
      total     <= total_next;
      time_now  <= time_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == lruk_pkg::S_IDLE) begin
        scan_cnt <= '0;
      end else if (state == lruk_pkg::S_EV_SCAN) begin
        scan_cnt <= scan_cnt + SCW'(1);
      end
      s1_valid <= issue && present[scan_j] && evictable[scan_j];
      s2_valid <= s1_valid;
      if (req_fire) begin
        best_have <= 1'b0;
      end else if (better) begin
        best_have <= 1'b1;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_fire) begin
      op_frame <= f_idx;
    end
    s1_j   <= scan_j;
    s2_j   <= s1_j;
    s2_inf <= s1_inf;
    if (better) begin
      best_j   <= s2_j;
      best_inf <= s2_inf;
      best_old <= hist_rdata;
    end
    if ((state == lruk_pkg::S_IDLE && req_fire) || state == lruk_pkg::S_ACC_WR ||
        state == lruk_pkg::S_EV_DONE) begin
      pend <= pend_next;
    end
    if (rsp_load) begin
      rsp <= pend;
    end
  end

  lruk_ram #(
    .WIDTH(MW),
    .DEPTH(FRAMES)
  ) u_meta_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(op_frame),
    .wdata(meta_wdata),
    .raddr(meta_raddr),
    .rdata(meta_rdata)
  );

  lruk_ram #(
    .WIDTH(TIME_BITS),
    .DEPTH(FRAMES << SW)
  ) u_hist_ram (
    .clk  (clk),
    .we   (mem_we),
    .waddr(hist_waddr),
    .wdata(time_now),
    .raddr(hist_raddr),
    .rdata(hist_rdata)
  );

  // Only tracked frames may be evictable
  a_evictable_tracked: assert property (@(posedge clk) disable iff (rst)
    (evictable & ~present) == '0)
    else $error("evictable flag set on an untracked frame");

  // Running count matches the flags
  a_total_matches: assert property (@(posedge clk) disable iff (rst)
    TW'($countones(evictable)) == total)
    else $error("evictable count out of step with flags");

  // The chosen victim is still evictable when it is cleared
  a_victim_evictable: assert property (@(posedge clk) disable iff (rst)
    (state == lruk_pkg::S_EV_DONE && best_have) |-> evictable[best_j])
    else $error("victim is not an evictable frame");

  // Evict starts its scan at frame zero
  a_scan_start: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req.cmd == lruk_pkg::CMD_EVICT) |=>
      (state == lruk_pkg::S_EV_SCAN && scan_cnt == '0 && !best_have))
    else $error("evict scan did not start cleanly");

  // The scan never runs past the pipeline drain
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == lruk_pkg::S_EV_SCAN) |-> (32'(scan_cnt) <= FRAMES + 1))
    else $error("evict scan counter overran");

endmodule
